FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is held.
`define RWB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RWB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rwb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rwb_pkg;

    localparam int ENTRIES      = 32;
    localparam int PER_PACKET   = 8;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int HELD_W       = IDX_W + 1;
    localparam int PICK_W       = $clog2(PER_PACKET + 1);
    localparam int PSEL_W       = (PER_PACKET > 1) ? $clog2(PER_PACKET) : 1;
    localparam int SEQ_W        = 31;
    localparam int SLOT_W       = 5;
    localparam int PAYLOAD_W    = 64;
    localparam int LIMIT_W      = 5;
    localparam int COUNT_W      = 3;
    localparam int OP_W         = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 3'd7;
    localparam logic [COUNT_W-1:0] MAX_SENDS_RST  = 3'd2;

    typedef enum logic [OP_W-1:0] {
        OP_SEND      = 3'd0,
        OP_PACK      = 3'd1,
        OP_ACK_ARR   = 3'd2,
        OP_ACK_LOST  = 3'd3,
        OP_FIND      = 3'd4,
        OP_GET_NEXT  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_ACK,
        ST_FIND,
        ST_FETCH,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [SLOT_W-1:0]    slot;
        logic [PAYLOAD_W-1:0] payload;
        logic [LIMIT_W-1:0]   move_limit;
        logic [4:0]           entry_index;
        logic [SEQ_W-1:0]     seq;
    } cmd_t;

    typedef struct packed {
        logic                 found;
        logic [4:0]           entry_index_res;
        logic [SEQ_W-1:0]     item_seq;
        logic [SLOT_W-1:0]    item_slot;
        logic [PAYLOAD_W-1:0] item_payload;
        logic                 overflow;
        logic                 last;
    } rsp_t;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [SLOT_W-1:0]    slot;
        logic [SEQ_W-1:0]     seq;
    } mem_word_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(ENTRIES - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(ENTRIES - 1) : i - 1'b1;
    endfunction

endpackage
`default_nettype wire

FILE: src/rwb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rwb_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/retransmit_window_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Retransmission window ring of ENTRIES items (payload, slot, sequence, send count).
// Request channel: cmd_valid / cmd_stall carry one cmd_t request; a request is taken
// when cmd_valid is high and cmd_stall low. cmd_stall stays high while a request is
// being worked on, so requests are handled one at a time.
// Response channel: rsp_valid / rsp_stall carry rsp_t results; rsp.last marks the
// final result of a request. A stalled response holds in the output register and
// the engine waits on it; a pack emits up to PER_PACKET results, one per handover.
// Configuration: cfg_valid / cfg_ready write max_sends; cfg_ready is always high.
// A pack scans up to the held count of items. A find walks the single-read-port
// item memory one entry a cycle, over all ENTRIES entries on a miss, and a match
// ends the walk early. Send counts and valid bits live in flip-flops and are read
// one address at a time.
// Reset clears positions, counts, valid bits, cursor and max_sends (to 2); item
// memory is left as it is; an entry's data is used only once its valid bit is set.
module retransmit_window_buffer_core
    import rwb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire cmd_t               cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rsp_t                    rsp,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data
);

`include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   rp_reg, rp_next;
    logic [IDX_W-1:0]   wp_reg, wp_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [IDX_W-1:0]   cursor_reg, cursor_next;
    logic               cursor_ok_reg, cursor_ok_next;
    logic [COUNT_W-1:0] max_sends_reg;
    logic               vbit_reg [ENTRIES];
    logic               vbit_next [ENTRIES];
    logic [COUNT_W-1:0] count_reg [ENTRIES];
    logic [COUNT_W-1:0] count_next [ENTRIES];

    cmd_t               cmd_reg;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [HELD_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]   pick_reg [PER_PACKET];
    logic [IDX_W-1:0]   pick_next [PER_PACKET];
    logic [PICK_W-1:0]  npick_reg, npick_next;
    logic [PICK_W-1:0]  emit_reg, emit_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic [HELD_W-1:0]  fcnt_reg, fcnt_next;
    logic               cmp_ok_reg, cmp_ok_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   best_reg, best_next;
    logic               have_reg, have_next;
    logic [IDX_W-1:0]   ridx_reg, ridx_next;
    rsp_t               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg;

    logic               accept;
    logic               out_free;
    logic [LIMIT_W-1:0] cap;
    logic               scan_go;
    logic               gn_ok;
    logic               is_pack;
    logic               find_match;
    logic               find_end;
    logic [IDX_W-1:0]   vaddr;
    logic [IDX_W-1:0]   caddr;
    logic               v_rd;
    logic [COUNT_W-1:0] c_rd;
    logic [IDX_W-1:0]   pick_cur;
    logic               ack_hit;
    rsp_t               miss;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    mem_word_t          ram_wdata;
    mem_word_t          ram_rdata;

    rwb_ram #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(mem_word_t))
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign is_pack   = (op_t'(cmd_reg.operation) == OP_PACK);
    assign gn_ok     = cursor_ok_reg && (cursor_reg != wp_reg);

    // pack takes at most the smaller of the request limit and the packet size
    assign cap     = (cmd_reg.move_limit < LIMIT_W'(PER_PACKET)) ?
                     cmd_reg.move_limit : LIMIT_W'(PER_PACKET);
    assign scan_go = (scan_cnt_reg < held_reg) && (LIMIT_W'(npick_reg) < cap);

    assign pick_cur = pick_reg[emit_reg[PSEL_W-1:0]];

    // one read address each for the valid bits and the send counts
    assign vaddr = (state_reg == ST_ACK) ? cmd_reg.entry_index[IDX_W-1:0] : cmp_idx_reg;
    always_comb
    begin
        unique case (state_reg)
            ST_SCAN: caddr = scan_idx_reg;
            ST_ACK:  caddr = cmd_reg.entry_index[IDX_W-1:0];
            default: caddr = pick_cur;
        endcase
    end
    assign v_rd = vbit_reg[vaddr];
    assign c_rd = count_reg[caddr];

    assign find_match = (state_reg == ST_FIND) && cmp_ok_reg && v_rd
                        && (ram_rdata.seq == cmd_reg.seq);
    assign find_end   = !cmp_ok_reg && (fcnt_reg == HELD_W'(ENTRIES));

    always_comb
    begin
        ack_hit = v_rd && (ram_rdata.seq == cmd_reg.seq);
        if (op_t'(cmd_reg.operation) == OP_ACK_ARR)
        begin
            ack_hit = ack_hit && (held_reg != '0)
                      && (cmd_reg.entry_index[IDX_W-1:0] == rp_reg);
        end
    end

    always_comb
    begin
        miss      = '0;
        miss.last = 1'b1;
    end

    // the memory write takes the request fields straight from the port
    always_comb
    begin
        ram_wdata.payload = cmd.payload;
        ram_wdata.slot    = cmd.slot;
        ram_wdata.seq     = seq_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(cmd.operation))
                        OP_SEND:     state_next = ST_PUT;
                        OP_PACK:     state_next = ST_SCAN;
                        OP_ACK_ARR:  state_next = ST_ACK;
                        OP_ACK_LOST: state_next = ST_ACK;
                        OP_FIND:     state_next = ST_FIND;
                        OP_GET_NEXT: state_next = gn_ok ? ST_FETCH : ST_PUT;
                        default:     state_next = ST_PUT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!scan_go)
                begin
                    state_next = (npick_reg == '0) ? ST_PUT : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_FETCH;
            ST_ACK:     state_next = ST_PUT;
            ST_FETCH:   state_next = ST_PUT;
            ST_FIND:
            begin
                if (find_match)
                begin
                    state_next = ST_FETCH;
                end
                else if (find_end)
                begin
                    state_next = have_reg ? ST_FETCH : ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = (is_pack && !pend_reg.last) ? ST_EMIT_RD : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        held_next      = held_reg;
        seq_next       = seq_reg;
        cursor_next    = cursor_reg;
        cursor_ok_next = cursor_ok_reg;
        vbit_next      = vbit_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        scan_cnt_next  = scan_cnt_reg;
        pick_next      = pick_reg;
        npick_next     = npick_reg;
        emit_next      = emit_reg;
        fidx_next      = fidx_reg;
        fcnt_next      = fcnt_reg;
        cmp_ok_next    = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        ridx_next      = ridx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = cmd_reg.entry_index[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(cmd.operation))
                        OP_PACK:
                        begin
                            scan_idx_next = rp_reg;
                            scan_cnt_next = '0;
                            npick_next    = '0;
                            emit_next     = '0;
                        end
                        OP_ACK_ARR, OP_ACK_LOST:
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = cmd.entry_index[IDX_W-1:0];
                        end
                        OP_FIND:
                        begin
                            fidx_next = wp_reg;
                            fcnt_next = '0;
                            have_next = 1'b0;
                        end
                        OP_GET_NEXT:
                        begin
                            if (gn_ok)
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = cursor_reg;
                                ridx_next   = cursor_reg;
                                cursor_next = wrap_inc(cursor_reg);
                            end
                            else
                            begin
                                pend_next = miss;
                            end
                        end
                        OP_SEND:
                        begin
                            pend_next = miss;
                        end
                        default:
                        begin
                            pend_next = miss;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (is_pack && !pend_reg.last)
                    begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_go)
                begin
                    if (c_rd < max_sends_reg)
                    begin
                        pick_next[npick_reg[PSEL_W-1:0]] = scan_idx_reg;
                        npick_next = npick_reg + 1'b1;
                    end
                    scan_idx_next = wrap_inc(scan_idx_reg);
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else if (npick_reg == '0)
                begin
                    pend_next = miss;
                end
            end
            ST_EMIT_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = pick_cur;
                ridx_next = pick_cur;
                if (c_rd != COUNT_MAX)
                begin
                    count_next[pick_cur] = c_rd + 1'b1;
                end
            end
            ST_ACK:
            begin
                if (ack_hit)
                begin
                    if (op_t'(cmd_reg.operation) == OP_ACK_ARR)
                    begin
                        count_next[cmd_reg.entry_index[IDX_W-1:0]] = '0;
                        rp_next   = wrap_inc(rp_reg);
                        held_next = held_reg - 1'b1;
                    end
                    else if (c_rd != '0)
                    begin
                        count_next[cmd_reg.entry_index[IDX_W-1:0]] = c_rd - 1'b1;
                    end
                    pend_next.found           = 1'b1;
                    pend_next.entry_index_res = 5'(cmd_reg.entry_index[IDX_W-1:0]);
                    pend_next.item_seq        = ram_rdata.seq;
                    pend_next.item_slot       = ram_rdata.slot;
                    pend_next.item_payload    = ram_rdata.payload;
                    pend_next.overflow        = 1'b0;
                    pend_next.last            = 1'b1;
                end
                else
                begin
                    pend_next = miss;
                end
            end
            ST_FIND:
            begin
                if (cmp_ok_reg && v_rd && !find_match && (ram_rdata.seq > cmd_reg.seq))
                begin
                    best_next = cmp_idx_reg;
                    have_next = 1'b1;
                end
                if (find_match)
                begin
                    // hold read data: no further read once the match is seen
                    ridx_next      = cmp_idx_reg;
                    cursor_next    = wrap_inc(cmp_idx_reg);
                    cursor_ok_next = 1'b1;
                end
                else if (find_end)
                begin
                    cursor_ok_next = 1'b1;
                    if (have_reg)
                    begin
                        cursor_next = best_reg;
                        ridx_next   = best_reg;
                        ram_re      = 1'b1;
                        ram_raddr   = best_reg;
                    end
                    else
                    begin
                        cursor_next = wp_reg;
                        pend_next   = miss;
                    end
                end
                else if (fcnt_reg != HELD_W'(ENTRIES))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = fidx_reg;
                    cmp_idx_next = fidx_reg;
                    cmp_ok_next  = 1'b1;
                    fidx_next    = wrap_dec(fidx_reg);
                    fcnt_next    = fcnt_reg + 1'b1;
                end
            end
            ST_FETCH:
            begin
                pend_next.found           = 1'b1;
                pend_next.entry_index_res = 5'(ridx_reg);
                pend_next.item_seq        = ram_rdata.seq;
                pend_next.item_slot       = ram_rdata.slot;
                pend_next.item_payload    = ram_rdata.payload;
                pend_next.overflow        = 1'b0;
                pend_next.last            = is_pack ?
                                            (emit_reg + 1'b1 == npick_reg) : 1'b1;
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase

        // send: write the item and advance the ring in the accept cycle
        if (state_reg == ST_IDLE && accept && op_t'(cmd.operation) == OP_SEND)
        begin
            ram_we                    = 1'b1;
            pend_next.found           = 1'b1;
            pend_next.entry_index_res = 5'(wp_reg);
            pend_next.item_seq        = seq_reg;
            pend_next.item_slot       = cmd.slot;
            pend_next.item_payload    = cmd.payload;
            pend_next.overflow        = (held_reg >= HELD_W'(ENTRIES - 1));
            pend_next.last            = 1'b1;
            if (held_reg >= HELD_W'(ENTRIES - 1))
            begin
                rp_next = wrap_inc(rp_reg);
            end
            else
            begin
                held_next = held_reg + 1'b1;
            end
            vbit_next[wp_reg]  = 1'b1;
            count_next[wp_reg] = '0;
            seq_next           = seq_reg + 1'b1;
            wp_next            = wrap_inc(wp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            held_reg      <= '0;
            seq_reg       <= '0;
            cursor_reg    <= '0;
            cursor_ok_reg <= 1'b0;
            max_sends_reg <= MAX_SENDS_RST;
            for (int i = 0; i < ENTRIES; i++)
            begin
                vbit_reg[i]  <= 1'b0;
                count_reg[i] <= '0;
            end
            scan_idx_reg  <= '0;
            scan_cnt_reg  <= '0;
            npick_reg     <= '0;
            emit_reg      <= '0;
            fidx_reg      <= '0;
            fcnt_reg      <= '0;
            cmp_ok_reg    <= 1'b0;
            cmp_idx_reg   <= '0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            ridx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            held_reg      <= held_next;
            seq_reg       <= seq_next;
            cursor_reg    <= cursor_next;
            cursor_ok_reg <= cursor_ok_next;
            if (cfg_valid && cfg_ready)
            begin
                max_sends_reg <= cfg_data;
            end
            vbit_reg      <= vbit_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            scan_cnt_reg  <= scan_cnt_next;
            npick_reg     <= npick_next;
            emit_reg      <= emit_next;
            fidx_reg      <= fidx_next;
            fcnt_reg      <= fcnt_next;
            cmp_ok_reg    <= cmp_ok_next;
            cmp_idx_reg   <= cmp_idx_next;
            best_reg      <= best_next;
            have_reg      <= have_next;
            ridx_reg      <= ridx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        pick_reg <= pick_next;
        pend_reg <= pend_next;
        if (state_reg == ST_PUT && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    `RWB_ASSERT(a_held_bound, clk, rst_n, held_reg <= HELD_W'(ENTRIES - 1), "ring over-full")
    `RWB_ASSERT(a_busy_after_take, clk, rst_n, accept |=> state_reg != ST_IDLE, "request not held")
    `RWB_ASSERT(a_miss_zero, clk, rst_n, (rsp_valid && !rsp.found) |-> (rsp.item_payload == '0 && rsp.item_seq == '0), "miss carries data")
    `RWB_ASSERT(a_pick_bound, clk, rst_n, npick_reg <= PICK_W'(PER_PACKET), "too many picks")

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import rwb_pkg::*;

    // Operation codes that the block must answer with a bare "not found".
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int RING = ENTRIES;
    localparam int RUN_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    retransmit_window_buffer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock: 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the ring, kept in step with every accepted request
    // ---------------------------------------------------------------
    logic [PAYLOAD_W-1:0] sh_payload [RING];
    logic [SLOT_W-1:0]    sh_slot    [RING];
    logic [SEQ_W-1:0]     sh_seq     [RING];
    logic                 sh_written [RING];
    logic [COUNT_W-1:0]   sh_count   [RING];
    logic [IDX_W-1:0]     rd_pos;
    logic [IDX_W-1:0]     wr_pos;
    int unsigned          held;
    logic [SEQ_W-1:0]     seq_next;
    logic [IDX_W-1:0]     cursor;
    logic                 cursor_ok;
    logic [COUNT_W-1:0]   max_sends;

    // Results still owed by the block, oldest first
    rsp_t pending_rsp [$];

    int errors;
    int tx_pct;
    int rx_pct;
    bit hold_req;
    longint cycles;

    function automatic rsp_t item_rsp(input logic [IDX_W-1:0] idx, input logic ovf,
                                      input logic lst);
        rsp_t r;
        r = '0;
        r.found = 1'b1;
        r.entry_index_res = idx;
        if (sh_written[idx])
        begin
            r.item_seq = sh_seq[idx];
            r.item_slot = sh_slot[idx];
            r.item_payload = sh_payload[idx];
        end
        r.overflow = ovf;
        r.last = lst;
        return r;
    endfunction

    function automatic rsp_t miss_rsp();
        rsp_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // Advance the shadow ring by one request and queue the results it owes.
    function automatic void window_step(input cmd_t c);
        logic [IDX_W-1:0] picks [$];
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] best;
        logic ovf;
        bit have;
        int unsigned cap;
        int unsigned scanned;
        case (c.operation)
            OP_SEND:
            begin
                ovf = 1'b0;
                idx = wr_pos;
                if (held >= RING - 1)
                begin
                    rd_pos = rd_pos + 1'b1;
                    held--;
                    ovf = 1'b1;
                end
                sh_payload[idx] = c.payload;
                sh_slot[idx] = c.slot;
                sh_seq[idx] = seq_next;
                sh_written[idx] = 1'b1;
                sh_count[idx] = '0;
                seq_next = seq_next + 1'b1;
                wr_pos = idx + 1'b1;
                held++;
                pending_rsp.push_back(item_rsp(idx, ovf, 1'b1));
            end
            OP_PACK:
            begin
                cap = (c.move_limit < PER_PACKET) ? c.move_limit : PER_PACKET;
                idx = rd_pos;
                for (scanned = 0; scanned < held && picks.size() < cap; scanned++)
                begin
                    if (sh_count[idx] < max_sends)
                        picks.push_back(idx);
                    idx = idx + 1'b1;
                end
                if (picks.size() == 0)
                    pending_rsp.push_back(miss_rsp());
                foreach (picks[k])
                begin
                    if (sh_count[picks[k]] != COUNT_MAX)
                        sh_count[picks[k]]++;
                    pending_rsp.push_back(item_rsp(picks[k], 1'b0, k == picks.size() - 1));
                end
            end
            OP_ACK_ARR:
            begin
                idx = c.entry_index;
                if (held > 0 && idx == rd_pos && sh_written[idx] && sh_seq[idx] == c.seq)
                begin
                    sh_count[idx] = '0;
                    rd_pos = rd_pos + 1'b1;
                    held--;
                    pending_rsp.push_back(item_rsp(idx, 1'b0, 1'b1));
                end
                else
                    pending_rsp.push_back(miss_rsp());
            end
            OP_ACK_LOST:
            begin
                idx = c.entry_index;
                if (sh_written[idx] && sh_seq[idx] == c.seq)
                begin
                    if (sh_count[idx] != 0)
                        sh_count[idx]--;
                    pending_rsp.push_back(item_rsp(idx, 1'b0, 1'b1));
                end
                else
                    pending_rsp.push_back(miss_rsp());
            end
            OP_FIND:
            begin
                // Walk backward from the write position; an exact hit wins at once,
                // otherwise keep the last larger sequence met on the way.
                idx = wr_pos;
                have = 0;
                best = '0;
                cursor_ok = 1'b1;
                for (int n = 0; n < RING; n++)
                begin
                    if (sh_written[idx])
                    begin
                        if (sh_seq[idx] == c.seq)
                        begin
                            cursor = idx + 1'b1;
                            pending_rsp.push_back(item_rsp(idx, 1'b0, 1'b1));
                            return;
                        end
                        if (sh_seq[idx] > c.seq)
                        begin
                            best = idx;
                            have = 1;
                        end
                    end
                    idx = idx - 1'b1;
                end
                if (!have)
                begin
                    cursor = wr_pos;
                    pending_rsp.push_back(miss_rsp());
                end
                else
                begin
                    cursor = best;
                    pending_rsp.push_back(item_rsp(best, 1'b0, 1'b1));
                end
            end
            OP_GET_NEXT:
            begin
                if (!cursor_ok || cursor == wr_pos)
                    pending_rsp.push_back(miss_rsp());
                else
                begin
                    pending_rsp.push_back(item_rsp(cursor, 1'b0, 1'b1));
                    cursor = cursor + 1'b1;
                end
            end
            default:
                pending_rsp.push_back(miss_rsp());
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Response checking: sample mid-cycle, handover follows at the next edge
    // ---------------------------------------------------------------
    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report("unexpected response, found", rsp.found, 0);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.found !== want.found)
                    report("found", rsp.found, want.found);
                if (rsp.entry_index_res !== want.entry_index_res)
                    report("entry_index_res", rsp.entry_index_res, want.entry_index_res);
                if (rsp.item_seq !== want.item_seq)
                    report("item_seq", rsp.item_seq, want.item_seq);
                if (rsp.item_slot !== want.item_slot)
                    report("item_slot", rsp.item_slot, want.item_slot);
                if (rsp.item_payload !== want.item_payload)
                    report("item_payload", rsp.item_payload, want.item_payload);
                if (rsp.overflow !== want.overflow)
                    report("overflow", rsp.overflow, want.overflow);
                if (rsp.last !== want.last)
                    report("last", rsp.last, want.last);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Request side. The issue and write_max_sends tasks return at the edge that took their request.
    // ---------------------------------------------------------------
    task automatic issue(input cmd_t c);
        int gap;
        gap = ($urandom_range(0, 99) < tx_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(negedge clk);
        while (cmd_stall);
        @(posedge clk);
        window_step(c);
    endtask

    // Drop valid, let every owed result drain, then hold for the slowest scan.
    task automatic settle();
        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_sends(input logic [COUNT_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        max_sends = v;
    endtask

    function automatic cmd_t make_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] sl,
                                      input logic [PAYLOAD_W-1:0] pay,
                                      input logic [LIMIT_W-1:0] lim, input logic [4:0] ix,
                                      input logic [SEQ_W-1:0] sq);
        cmd_t c;
        c.operation = op;
        c.slot = sl;
        c.payload = pay;
        c.move_limit = lim;
        c.entry_index = ix;
        c.seq = sq;
        return c;
    endfunction

    // Random request, mostly well formed against the shadow ring.
    function automatic cmd_t random_cmd();
        cmd_t c;
        int pick;
        logic [IDX_W-1:0] ix;
        c.operation = OP_SEND;
        c.slot = SLOT_W'($urandom_range(0, 31));
        c.payload = {$urandom(), $urandom()};
        c.move_limit = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom_range(0, 31))
                                                   : LIMIT_W'($urandom_range(0, 10));
        c.entry_index = 5'($urandom_range(0, 31));
        c.seq = SEQ_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 34)
            c.operation = OP_SEND;
        else if (pick < 54)
            c.operation = OP_PACK;
        else if (pick < 69)
        begin
            c.operation = OP_ACK_ARR;
            if (held > 0 && $urandom_range(0, 4) != 0)
            begin
                c.entry_index = rd_pos;
                c.seq = sh_seq[rd_pos];
            end
        end
        else if (pick < 79)
        begin
            c.operation = OP_ACK_LOST;
            ix = c.entry_index;
            if (sh_written[ix] && $urandom_range(0, 3) != 0)
                c.seq = sh_seq[ix];
        end
        else if (pick < 88)
        begin
            c.operation = OP_FIND;
            if ($urandom_range(0, 3) != 0)
                c.seq = seq_next - SEQ_W'($urandom_range(0, 40));
        end
        else if (pick < 97)
            c.operation = OP_GET_NEXT;
        else
            c.operation = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        return c;
    endfunction

    typedef struct {
        cmd_t c;
        bit   typed;
        rsp_t want;
    } vector_t;

    vector_t vectors [$];

    function automatic void add(input cmd_t c);
        vector_t v;
        v.c = c;
        v.typed = 0;
        v.want = '0;
        vectors.push_back(v);
    endfunction

    function automatic void add_typed(input cmd_t c, input rsp_t w);
        vector_t v;
        v.c = c;
        v.typed = 1;
        v.want = w;
        vectors.push_back(v);
    endfunction

    function automatic rsp_t hit(input logic [4:0] ix, input logic [SEQ_W-1:0] sq,
                                 input logic [SLOT_W-1:0] sl,
                                 input logic [PAYLOAD_W-1:0] pay);
        rsp_t r;
        r = '0;
        r.found = 1'b1;
        r.entry_index_res = ix;
        r.item_seq = sq;
        r.item_slot = sl;
        r.item_payload = pay;
        r.last = 1'b1;
        return r;
    endfunction

    initial
    begin
        localparam logic [PAYLOAD_W-1:0] ONES = '1;
        rsp_t none;
        none = miss_rsp();
        errors = 0;
        cycles = 0;
        hold_req = 0;
        tx_pct = 33;
        rx_pct = 68;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        foreach (sh_written[i])
        begin
            sh_written[i] = 1'b0;
            sh_count[i] = '0;
            sh_payload[i] = '0;
            sh_slot[i] = '0;
            sh_seq[i] = '0;
        end
        rd_pos = '0;
        wr_pos = '0;
        held = 0;
        seq_next = '0;
        cursor = '0;
        cursor_ok = 1'b0;
        max_sends = MAX_SENDS_RST;

        // Directed table: empty ring, extremes, acks right and wrong, replay.
        add_typed(make_cmd(OP_GET_NEXT, 0, 0, 0, 0, 0), none);          // no find yet
        add_typed(make_cmd(OP_PACK, 0, 0, 31, 0, 0), none);             // nothing held
        add_typed(make_cmd(OP_ACK_ARR, 0, 0, 0, 0, 0), none);           // empty ring
        add_typed(make_cmd(OP_ACK_LOST, 0, 0, 0, 0, 0), none);          // never written
        add_typed(make_cmd(OP_FIND, 0, 0, 0, 0, 0), none);              // miss
        add(make_cmd(OP_GET_NEXT, 0, 0, 0, 0, 0));                      // cursor at write
        add_typed(make_cmd(OP_SEND, 31, ONES, 0, 0, 0), hit(0, 0, 31, ONES));
        add_typed(make_cmd(OP_SEND, 0, 0, 31, 31, 31'h7fff_ffff), hit(1, 1, 0, 0));
        add(make_cmd(OP_SEND, 5'd17, 64'h0123_4567_89ab_cdef, 0, 0, 0));
        add_typed(make_cmd(OP_PACK, 0, 0, 0, 0, 0), none);              // limit zero
        add(make_cmd(OP_PACK, 0, 0, 31, 0, 0));
        add(make_cmd(OP_PACK, 0, 0, 1, 0, 0));
        add(make_cmd(OP_PACK, 0, 0, 31, 0, 0));                         // some at max sends
        add(make_cmd(OP_ACK_LOST, 0, 0, 0, 0, 0));
        add_typed(make_cmd(OP_ACK_LOST, 0, 0, 0, 1, 5), none);          // wrong seq
        add_typed(make_cmd(OP_ACK_ARR, 0, 0, 0, 1, 1), none);           // not at read pos
        add_typed(make_cmd(OP_ACK_ARR, 0, 0, 0, 0, 0), hit(0, 0, 31, ONES));
        add(make_cmd(OP_FIND, 0, 0, 0, 0, 1));
        add(make_cmd(OP_GET_NEXT, 0, 0, 0, 0, 0));
        add(make_cmd(OP_GET_NEXT, 0, 0, 0, 0, 0));                      // runs into write
        add_typed(make_cmd(OP_FIND, 0, 0, 0, 0, 31'h7fff_ffff), none);
        add(make_cmd(OP_FIND, 0, 0, 0, 0, 0));                          // freed, still there
        add_typed(make_cmd(OP_SPARE_6, 31, ONES, 31, 31, 31'h7fff_ffff), none);
        add_typed(make_cmd(OP_SPARE_7, 0, 0, 0, 0, 0), none);
        add_typed(make_cmd(OP_ACK_LOST, 0, 0, 0, 31, 31'h7fff_ffff), none);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[k])
        begin
            issue(vectors[k].c);
            // Swap the predicted result for the typed one where a row carries it.
            if (vectors[k].typed)
                pending_rsp[pending_rsp.size() - 1] = vectors[k].want;
        end

        // Phase one: top send count, long receiver hold-off at its start.
        write_max_sends(3'd7);
        hold_req = 1;
        repeat (140) issue(random_cmd());

        // Phase two: single send, roles of the idlers swapped.
        write_max_sends(3'd1);
        tx_pct = 68;
        rx_pct = 33;
        repeat (140) issue(random_cmd());

        // Phase three: mid setting, nobody idles.
        write_max_sends(3'd4);
        tx_pct = 0;
        rx_pct = 0;
        repeat (140) issue(random_cmd());

        settle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
